/* src/kuff_pkg.sv */
`timescale 1ns / 1ps
package kuff_pkg;

  localparam int VERTEX_W  = 10;
  localparam int WEIGHT_W  = 32;
  localparam int COUNT_W   = 11;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] REG_VERTEX_COUNT    = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SATELLITE_COUNT = 1'd1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_A_WALK,
    ST_A_COMP,
    ST_B_WALK,
    ST_B_COMP,
    ST_LINK,
    ST_RESULT
  } kuff_state_t;

  // source of the parent-store read address (and of the next walk node)
  typedef enum logic [1:0] {
    RD_IN_FROM,
    RD_FROM,
    RD_TO,
    RD_LINK
  } rd_src_t;

  typedef enum logic {
    SIDE_FROM,
    SIDE_TO
  } side_t;

  typedef struct packed {
    logic    capture;
    logic    rd_en;
    rd_src_t rd_src;
    logic    root_we;
    side_t   side;
    logic    comp_we;
    logic    link;
    logic    load_out;
    logic    run_clear;
    logic    clear_step;
  } kuff_cmd_t;

  typedef struct packed {
    logic live;
    logic at_root;
    logic clr_last;
    logic out_free;
    logic last;
  } kuff_status_t;

endpackage

/* src/kuff_edge_if.sv */
`timescale 1ns / 1ps
interface kuff_edge_if;
  logic                          valid;
  logic                          ready;
  logic [kuff_pkg::VERTEX_W-1:0] from_vertex;
  logic [kuff_pkg::VERTEX_W-1:0] to_vertex;
  logic [kuff_pkg::WEIGHT_W-1:0] edge_weight;
  logic                          last_edge;

  modport source (output valid, output from_vertex, output to_vertex,
                  output edge_weight, output last_edge, input ready);
  modport sink   (input valid, input from_vertex, input to_vertex,
                  input edge_weight, input last_edge, output ready);
endinterface

/* src/kuff_result_if.sv */
`timescale 1ns / 1ps
interface kuff_result_if;
  logic                         valid;
  logic                         ready;
  logic                         in_forest;
  logic [kuff_pkg::COUNT_W-1:0] forest_edges;
  logic [kuff_pkg::WEIGHT_W-1:0] max_weight;
  logic                         run_done;

  modport source (output valid, output in_forest, output forest_edges,
                  output max_weight, output run_done, input ready);
  modport sink   (input valid, input in_forest, input forest_edges,
                  input max_weight, input run_done, output ready);
endinterface

/* src/kuff_ctrl.sv */
`timescale 1ns / 1ps
module kuff_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  kuff_pkg::kuff_status_t status,
  output kuff_pkg::kuff_cmd_t    cmd
);
  import kuff_pkg::*;

  kuff_state_t state_r;
  kuff_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: begin
        if (status.clr_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) state_nxt = status.live ? ST_A_WALK : ST_RESULT;
      end
      ST_A_WALK: begin
        if (status.at_root) state_nxt = ST_A_COMP;
      end
      ST_A_COMP: begin
        if (status.at_root) state_nxt = ST_B_WALK;
      end
      ST_B_WALK: begin
        if (status.at_root) state_nxt = ST_B_COMP;
      end
      ST_B_COMP: begin
        if (status.at_root) state_nxt = ST_LINK;
      end
      ST_LINK: begin
        state_nxt = ST_RESULT;
      end
      ST_RESULT: begin
        if (status.out_free) state_nxt = status.last ? ST_CLEAR : ST_IDLE;
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      ST_CLEAR: begin
        cmd.clear_step = 1'b1;
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          cmd.rd_en   = 1'b1;
          cmd.rd_src  = RD_IN_FROM;
        end
      end
      ST_A_WALK, ST_B_WALK: begin
        cmd.rd_en = 1'b1;
        cmd.side  = (state_r == ST_A_WALK) ? SIDE_FROM : SIDE_TO;
        if (status.at_root) begin
          // latch the root, then restart from the endpoint to compress
          cmd.root_we = 1'b1;
          cmd.rd_src  = (state_r == ST_A_WALK) ? RD_FROM : RD_TO;
        end else begin
          cmd.rd_src = RD_LINK;
        end
      end
      ST_A_COMP, ST_B_COMP: begin
        cmd.side = (state_r == ST_A_COMP) ? SIDE_FROM : SIDE_TO;
        if (status.at_root) begin
          if (state_r == ST_A_COMP) begin
            cmd.rd_en  = 1'b1;
            cmd.rd_src = RD_TO;
          end
        end else begin
          cmd.comp_we = 1'b1;
          cmd.rd_en   = 1'b1;
          cmd.rd_src  = RD_LINK;
        end
      end
      ST_LINK: begin
        cmd.link = 1'b1;
      end
      ST_RESULT: begin
        if (status.out_free) begin
          cmd.load_out  = 1'b1;
          cmd.run_clear = status.last;
        end
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  // every accepted edge takes the controller out of idle
  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r != ST_IDLE))
    else $error("accepted edge did not start processing");

  a_link_after_comp: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_LINK) |-> ($past(state_r) == ST_B_COMP))
    else $error("link entered without finishing second find");

  a_run_end_sweeps: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.run_clear |=> (state_r == ST_CLEAR))
    else $error("end of run did not start the store sweep");

endmodule

/* src/kuff_dp.sv */
`timescale 1ns / 1ps
module kuff_dp #(
  parameter int MAX_VERTICES = 1024,
  parameter int WEIGHT_BITS  = 32
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [kuff_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [kuff_pkg::COUNT_W-1:0]   cfg_data,
  input  logic [kuff_pkg::VERTEX_W-1:0]  in_from_vertex,
  input  logic [kuff_pkg::VERTEX_W-1:0]  in_to_vertex,
  input  logic [kuff_pkg::WEIGHT_W-1:0]  in_edge_weight,
  input  logic                           in_last_edge,
  input  logic                           out_ready,
  output logic                           out_valid,
  output logic                           out_in_forest,
  output logic [kuff_pkg::COUNT_W-1:0]   out_forest_edges,
  output logic [kuff_pkg::WEIGHT_W-1:0]  out_max_weight,
  output logic                           out_run_done,
  input  kuff_pkg::kuff_cmd_t            cmd,
  output kuff_pkg::kuff_status_t         status
);
  import kuff_pkg::*;

  localparam int AW = $clog2(MAX_VERTICES);
  localparam int WB = (WEIGHT_BITS < WEIGHT_W) ? WEIGHT_BITS : WEIGHT_W;
  localparam logic [AW-1:0] LAST_IDX = AW'(MAX_VERTICES - 1);

  logic [AW-1:0] mem [MAX_VERTICES];

  logic [AW-1:0]      rd_data_r;
  logic [AW-1:0]      cur_r;
  logic [AW-1:0]      root_a_r;
  logic [AW-1:0]      root_b_r;
  logic [AW-1:0]      from_r;
  logic [AW-1:0]      to_r;
  logic [AW-1:0]      clr_r;
  logic [WB-1:0]      weight_r;
  logic [WB-1:0]      largest_r;
  logic [COUNT_W-1:0] count_r;
  logic [COUNT_W-1:0] vc_r;
  logic [COUNT_W-1:0] sat_r;
  logic               finished_r;
  logic               taken_r;
  logic               last_r;
  logic               out_valid_r;
  logic               out_in_forest_r;
  logic [COUNT_W-1:0] out_forest_edges_r;
  logic [WEIGHT_W-1:0] out_max_weight_r;
  logic               out_run_done_r;

  logic [AW-1:0]      rd_addr;
  logic [AW-1:0]      root_sel;
  logic               mem_we;
  logic [AW-1:0]      mem_wa;
  logic [AW-1:0]      mem_wd;
  logic               in_range;
  logic               roots_differ;
  logic [COUNT_W-1:0] count_inc;
  logic               hit_target;

  always_comb begin
    unique case (cmd.rd_src)
      RD_IN_FROM: rd_addr = AW'(in_from_vertex);
      RD_FROM:    rd_addr = from_r;
      RD_TO:      rd_addr = to_r;
      RD_LINK:    rd_addr = rd_data_r;
      default:    rd_addr = rd_data_r;
    endcase
  end

  assign root_sel     = (cmd.side == SIDE_FROM) ? root_a_r : root_b_r;
  assign roots_differ = (root_a_r != root_b_r);
  assign count_inc    = count_r + COUNT_W'(1);
  assign hit_target   = (sat_r < vc_r) && (count_inc == (vc_r - sat_r));

  assign in_range = (COUNT_W'(in_from_vertex) < vc_r) && (COUNT_W'(in_to_vertex) < vc_r) &&
                    (32'(in_from_vertex) < MAX_VERTICES) &&
                    (32'(in_to_vertex) < MAX_VERTICES);

  // one write port: clearing sweep, compression, or the union link
  always_comb begin
    mem_we = 1'b0;
    mem_wa = clr_r;
    mem_wd = clr_r;
    if (cmd.clear_step) begin
      mem_we = 1'b1;
    end else if (cmd.comp_we) begin
      mem_we = 1'b1;
      mem_wa = cur_r;
      mem_wd = root_sel;
    end else if (cmd.link && roots_differ && !hit_target) begin
      mem_we = 1'b1;
      mem_wa = root_b_r;
      mem_wd = root_a_r;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    if (cmd.rd_en) rd_data_r <= mem[rd_addr];
  end

  // walk, edge payload and result beat registers
  always_ff @(posedge clk) begin
    if (cmd.rd_en) cur_r <= rd_addr;
    if (cmd.root_we) begin
      if (cmd.side == SIDE_FROM) root_a_r <= cur_r;
      else root_b_r <= cur_r;
    end
    if (cmd.capture) begin
      from_r   <= AW'(in_from_vertex);
      to_r     <= AW'(in_to_vertex);
      weight_r <= WB'(in_edge_weight);
      last_r   <= in_last_edge;
    end
    if (cmd.load_out) begin
      out_in_forest_r    <= taken_r;
      out_forest_edges_r <= count_r;
      out_max_weight_r   <= WEIGHT_W'(largest_r);
      out_run_done_r     <= finished_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vc_r        <= COUNT_W'(1);
      sat_r       <= '0;
      count_r     <= '0;
      largest_r   <= '0;
      finished_r  <= 1'b0;
      taken_r     <= 1'b0;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_VERTEX_COUNT:    vc_r  <= cfg_data;
          REG_SATELLITE_COUNT: sat_r <= cfg_data;
          default:             vc_r  <= vc_r;
        endcase
      end
      if (cmd.clear_step) clr_r <= clr_r + AW'(1);
      if (cmd.capture) taken_r <= 1'b0;
      if (cmd.link && roots_differ) begin
        taken_r <= 1'b1;
        count_r <= count_inc;
        if (weight_r > largest_r) largest_r <= weight_r;
        if (hit_target) finished_r <= 1'b1;
      end
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      // end of run: counters drop in the same cycle the result beat is loaded
      if (cmd.run_clear) begin
        count_r    <= '0;
        largest_r  <= '0;
        finished_r <= 1'b0;
        taken_r    <= 1'b0;
        clr_r      <= '0;
      end
    end
  end

  assign status.live     = in_range && !finished_r;
  assign status.at_root  = (rd_data_r == cur_r);
  assign status.clr_last = (clr_r == LAST_IDX);
  assign status.out_free = !out_valid_r || out_ready;
  assign status.last     = last_r;

  assign out_valid        = out_valid_r;
  assign out_in_forest    = out_in_forest_r;
  assign out_forest_edges = out_forest_edges_r;
  assign out_max_weight   = out_max_weight_r;
  assign out_run_done     = out_run_done_r;

  a_done_from_link: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(finished_r) |-> $past(cmd.link))
    else $error("run finished outside a link step");

  a_count_steps: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r != $past(count_r)) |->
      ((count_r == $past(count_r) + COUNT_W'(1)) || (count_r == '0)))
    else $error("forest edge count moved by more than one");

  a_same_root_no_take: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.link && !roots_differ) |=> (!taken_r && $stable(count_r)))
    else $error("edge taken with both endpoints in one tree");

endmodule

/* src/kruskal_union_find_forest_unit.sv */
`timescale 1ns / 1ps
// channel   dir  handshake     beat contents
// in_ch     in   valid/ready   from_vertex, to_vertex, edge_weight, last_edge
// out_ch    out  valid/ready   in_forest, forest_edges, max_weight, run_done
// cfg_*     in   cfg_we only   cfg_index selects vertex_count / satellite_count
//
// A live edge walks the parent links from both endpoints to their roots and
// compresses both paths before the link; a refused edge goes straight to its result.
// After reset and after every last_edge beat the parent store is swept back
// to identity, and in_ch is not ready during the sweep.
// The result beat waits in an output register while the next edge runs;
// only that edge's own result waits for out_ch to drain.
module kruskal_union_find_forest_unit #(
  parameter int MAX_VERTICES = 1024,
  parameter int WEIGHT_BITS  = 32
) (
  input  logic                           clk,
  input  logic                           rst_n,
  kuff_edge_if.sink                      in_ch,
  kuff_result_if.source                  out_ch,
  input  logic                           cfg_we,
  input  logic [kuff_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [kuff_pkg::COUNT_W-1:0]   cfg_data
);
  import kuff_pkg::*;

  kuff_cmd_t    cmd;
  kuff_status_t status;
  logic         in_ready;

  kuff_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  kuff_dp #(
    .MAX_VERTICES (MAX_VERTICES),
    .WEIGHT_BITS  (WEIGHT_BITS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_from_vertex   (in_ch.from_vertex),
    .in_to_vertex     (in_ch.to_vertex),
    .in_edge_weight   (in_ch.edge_weight),
    .in_last_edge     (in_ch.last_edge),
    .out_ready        (out_ch.ready),
    .out_valid        (out_ch.valid),
    .out_in_forest    (out_ch.in_forest),
    .out_forest_edges (out_ch.forest_edges),
    .out_max_weight   (out_ch.max_weight),
    .out_run_done     (out_ch.run_done),
    .cmd              (cmd),
    .status           (status)
  );

  assign in_ch.ready = in_ready;

endmodule
